FILE: hw/rtl/psc_pkg.sv
// shared types, constants and tables for the pursuit steering command pipeline
package psc_pkg;

  // fixed-point constants
  localparam int PI_Q16           = 205887;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int DEADBAND_RST     = 1966;
  localparam int STRENGTH_RST     = 19660800;

  // datapath widths
  localparam int CW        = 37;  // cordic x/y, covers gain on 33-bit inputs
  localparam int ZW        = 20;  // cordic angle, signed q4.16 radians
  localparam int SQW       = 68;  // radicand padded to whole bit pairs
  localparam int REMW      = 37;  // square root partial remainder
  localparam int DISTW     = 34;  // square root result
  localparam int PW        = 64;  // strength times offset magnitude
  localparam int SQ_STEPS  = SQW / 2;
  localparam int DIV_STEPS = 33;  // quotient bits 32..0, bits 32 and 31 flag saturation

  // pipeline depth: 4 prep stages, root cells, product stage, divide cells, output
  localparam int LAT        = 4 + SQ_STEPS + 1 + DIV_STEPS + 1;
  localparam int SIDE_DEPTH = SQ_STEPS + 1 + DIV_STEPS;

  // configuration register indexes
  typedef enum logic {
    REG_DEADBAND = 1'b0,
    REG_STRENGTH = 1'b1
  } reg_e;

  // angular command codes
  typedef enum logic [1:0] {
    TURN_STOP = 2'd0,
    TURN_POS  = 2'd1,
    TURN_NEG  = 2'd2
  } turn_e;

  // linear command kinds
  typedef enum logic {
    DRIVE_VEL   = 1'b0,
    DRIVE_FORCE = 1'b1
  } drive_e;

  // one cordic rotation state
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 fixed;
    logic signed [ZW-1:0] fz;
  } cordic_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [REMW-1:0]  rem;
    logic [DISTW-1:0] root;
    logic [SQW-1:0]   srest;
  } sqrt_t;

  // restoring divide state for both components
  typedef struct packed {
    logic [PW-1:0]        rem_x;
    logic [PW-1:0]        rem_y;
    logic [DIV_STEPS-1:0] q_x;
    logic [DIV_STEPS-1:0] q_y;
    logic [DISTW-1:0]     d;
  } div_t;

  // offset data that rides beside the root and divide cells
  typedef struct packed {
    logic               force_m;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        adx;
    logic [32:0]        ady;
  } side_t;

  // arctangent of 2^-i in q4.16
  function automatic logic signed [ZW-1:0] atan_q16(input int unsigned i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(51472);
      1:       v = ZW'(30386);
      2:       v = ZW'(16055);
      3:       v = ZW'(8150);
      4:       v = ZW'(4091);
      5:       v = ZW'(2047);
      6:       v = ZW'(1024);
      7:       v = ZW'(512);
      8:       v = ZW'(256);
      9:       v = ZW'(128);
      10:      v = ZW'(64);
      11:      v = ZW'(32);
      12:      v = ZW'(16);
      13:      v = ZW'(8);
      14:      v = ZW'(4);
      15:      v = ZW'(2);
      16:      v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/psc_cordic_cell.sv
// one vectoring cordic iteration with its output register
module psc_cordic_cell import psc_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t c_i,
  output cordic_t c_o
);

  logic signed [CW-1:0] xs, ys;
  cordic_t c_d, c_q;

  assign xs = c_i.x >>> STEP;
  assign ys = c_i.y >>> STEP;

  // rotate toward the x axis
  always_comb begin
    c_d = c_i;
    if (!c_i.y[CW-1]) begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + atan_q16(STEP);
    end else begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - atan_q16(STEP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_q <= c_d;
  end

  assign c_o = c_q;

endmodule

FILE: hw/rtl/psc_sqrt_cell.sv
// one result bit of the integer square root with its output register
module psc_sqrt_cell import psc_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t s_i,
  output sqrt_t s_o
);

  logic [REMW-1:0] rem2, trial;
  logic            ge;
  sqrt_t s_d, s_q;

  // bring down the next bit pair and try the new root bit
  assign rem2  = {s_i.rem[REMW-3:0], s_i.srest[SQW-1 -: 2]};
  assign trial = {1'b0, s_i.root, 2'b01};
  assign ge    = rem2 >= trial;

  always_comb begin
    s_d.rem   = ge ? rem2 - trial : rem2;
    s_d.root  = {s_i.root[DISTW-2:0], ge};
    s_d.srest = {s_i.srest[SQW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s_q <= s_d;
  end

  assign s_o = s_q;

endmodule

FILE: hw/rtl/psc_div_cell.sv
// one quotient bit of both force component divides with its output register
module psc_div_cell import psc_pkg::*; #(
  parameter int BIT = 0
) (
  input  logic clk_i,
  input  logic en_i,
  input  div_t v_i,
  output div_t v_o
);

  logic [PW+2:0] dsh;
  logic          ge_x, ge_y;
  div_t v_d, v_q;

  // shifted divisor, compared against both remainders
  assign dsh  = (PW+3)'(v_i.d) << BIT;
  assign ge_x = (PW+3)'(v_i.rem_x) >= dsh;
  assign ge_y = (PW+3)'(v_i.rem_y) >= dsh;

  always_comb begin
    v_d = v_i;
    v_d.q_x[BIT] = ge_x;
    v_d.q_y[BIT] = ge_y;
    if (ge_x) v_d.rem_x = v_i.rem_x - dsh[PW-1:0];
    if (ge_y) v_d.rem_y = v_i.rem_y - dsh[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) v_q <= v_d;
  end

  assign v_o = v_q;

endmodule

FILE: hw/rtl/pursuit_steering_command_top.sv
// Pursuit steering command: a fully pipelined datapath that takes one item per
// clock while the output is not stalled. Four prep stages form the offset,
// the squared distance and speed and the quaternion terms; two cordic cell rows
// give bearing and yaw; a row of 34 root cells gives the distance and a row of 33
// divide cells scales the offset to the force strength. The pipe depth is set by
// the root and divide rows; a result held on the output stalls the whole pipe.
// Configuration is written through the cfg channel, which is always ready.
module pursuit_steering_command_top import psc_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // target_x, target_y, self_x, self_y, vel_x, vel_y, quat_x, quat_y, quat_z, quat_w
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // turn_dir, cmd_x, cmd_y, zero fill
  output logic [71:0]  m_axis_tdata_o,
  // drive_mode
  output logic [0:0]   m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [0:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int TD = LAT - 5 - CORDIC_STEPS;
  localparam logic signed [ZW-1:0] PI_Z = ZW'(PI_Q16);

  logic adv;
  logic [LAT-1:0] vld_q;

  // configuration registers
  logic [15:0] db_q;
  logic [30:0] str_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      db_q  <= 16'(DEADBAND_RST);
      str_q <= 31'(STRENGTH_RST);
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_DEADBAND: db_q  <= cfg_data_i[15:0];
        REG_STRENGTH: str_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // pipe advance and valid line
  assign adv             = !vld_q[LAT-1] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid_i};
    end
  end

  // input fields
  logic signed [31:0] tx, ty, sx, sy, vx, vy;
  logic signed [15:0] qx, qy, qz, qw;

  assign tx = s_axis_tdata_i[31:0];
  assign ty = s_axis_tdata_i[63:32];
  assign sx = s_axis_tdata_i[95:64];
  assign sy = s_axis_tdata_i[127:96];
  assign vx = s_axis_tdata_i[159:128];
  assign vy = s_axis_tdata_i[191:160];
  assign qx = s_axis_tdata_i[207:192];
  assign qy = s_axis_tdata_i[223:208];
  assign qz = s_axis_tdata_i[239:224];
  assign qw = s_axis_tdata_i[255:240];

  // prep stage 1: offset, speed magnitudes, quaternion products
  logic signed [32:0] dx1_q, dy1_q;
  logic [31:0]        avx1_q, avy1_q;
  logic signed [31:0] pxx_q, pyy_q, pzz_q, pww_q, pxy_q, pwz_q, pxz_q, pwy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx1_q  <= {tx[31], tx} - {sx[31], sx};
      dy1_q  <= {ty[31], ty} - {sy[31], sy};
      avx1_q <= vx[31] ? 32'(-vx) : vx;
      avy1_q <= vy[31] ? 32'(-vy) : vy;
      pxx_q  <= qx * qx;
      pyy_q  <= qy * qy;
      pzz_q  <= qz * qz;
      pww_q  <= qw * qw;
      pxy_q  <= qx * qy;
      pwz_q  <= qw * qz;
      pxz_q  <= qx * qz;
      pwy_q  <= qw * qy;
    end
  end

  // prep stage 2: offset magnitudes, speed squares, yaw arguments
  logic signed [32:0] dx2_q, dy2_q;
  logic [32:0]        adx2_q, ady2_q;
  logic [63:0]        vx2_q, vy2_q;
  logic signed [33:0] n_d, n2_q, m20_2_q, yy2_q, yx2_q;

  assign n_d = 34'(pxx_q) + 34'(pyy_q) + 34'(pzz_q) + 34'(pww_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx2_q   <= dx1_q;
      dy2_q   <= dy1_q;
      adx2_q  <= dx1_q[32] ? 33'(-dx1_q) : 33'(dx1_q);
      ady2_q  <= dy1_q[32] ? 33'(-dy1_q) : 33'(dy1_q);
      vx2_q   <= avx1_q * avx1_q;
      vy2_q   <= avy1_q * avy1_q;
      n2_q    <= n_d;
      m20_2_q <= (34'(pxz_q) - 34'(pwy_q)) <<< 1;
      yy2_q   <= (34'(pxy_q) + 34'(pwz_q)) <<< 1;
      yx2_q   <= n_d - ((34'(pyy_q) + 34'(pzz_q)) <<< 1);
    end
  end

  // prep stage 3: offset squares and speed sum, cordic setup
  logic signed [32:0] dx3_q, dy3_q;
  logic [32:0]        adx3_q, ady3_q;
  logic [63:0]        sx2_q, sy2_q;
  logic [64:0]        vsq3_q;
  logic signed [33:0] am20;
  cordic_t            cb0_q, cy0_q;

  assign am20 = m20_2_q[33] ? -m20_2_q : m20_2_q;

  // special cases on the axis and quadrant fold before the iterations
  function automatic cordic_t cordic_prep(input logic signed [CW-1:0] y,
                                          input logic signed [CW-1:0] x,
                                          input logic zneg, input logic hold0);
    cordic_t c;
    c.x     = x;
    c.y     = y;
    c.z     = '0;
    c.fixed = 1'b0;
    c.fz    = '0;
    if (hold0) begin
      c.fixed = 1'b1;
    end else if (y == '0) begin
      c.fixed = 1'b1;
      if (x > 0)       c.fz = '0;
      else if (zneg)   c.fz = -PI_Z;
      else if (x < 0)  c.fz = PI_Z;
    end else if (x < 0) begin
      c.z = (y > 0) ? PI_Z : -PI_Z;
      c.x = -x;
      c.y = -y;
    end
    return c;
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      adx3_q <= adx2_q;
      ady3_q <= ady2_q;
      sx2_q  <= adx2_q * adx2_q;
      sy2_q  <= ady2_q * ady2_q;
      vsq3_q <= 65'(vx2_q) + 65'(vy2_q);
      cb0_q  <= cordic_prep(-(CW'(dy2_q)), -(CW'(dx2_q)), 1'b1, 1'b0);
      cy0_q  <= cordic_prep(CW'(yy2_q), CW'(yx2_q), 1'b0, am20 >= n2_q);
    end
  end

  // prep stage 4: squared distance and mode decision
  logic [64:0] s_d, s4_q;
  side_t       side4_q;

  assign s_d = 65'(sx2_q) + 65'(sy2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_q            <= s_d;
      side4_q.force_m <= s_d > vsq3_q;
      side4_q.dx      <= dx3_q;
      side4_q.dy      <= dy3_q;
      side4_q.adx     <= adx3_q;
      side4_q.ady     <= ady3_q;
    end
  end

  // cordic rows for bearing and yaw
  cordic_t cb [CORDIC_STEPS+1];
  cordic_t cy [CORDIC_STEPS+1];

  assign cb[0] = cb0_q;
  assign cy[0] = cy0_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    psc_cordic_cell #(.STEP(i)) u_bear (
      .clk_i (clk_i), .en_i (adv), .c_i (cb[i]), .c_o (cb[i+1])
    );
    psc_cordic_cell #(.STEP(i)) u_yaw (
      .clk_i (clk_i), .en_i (adv), .c_i (cy[i]), .c_o (cy[i+1])
    );
  end

  // heading error against the deadband
  logic signed [ZW-1:0] zb, zy;
  logic signed [ZW:0]   diff, dbs;
  turn_e                turn_d, turn_q;
  turn_e                tl_q [TD];

  assign zb   = cb[CORDIC_STEPS].fixed ? cb[CORDIC_STEPS].fz : cb[CORDIC_STEPS].z;
  assign zy   = cy[CORDIC_STEPS].fixed ? cy[CORDIC_STEPS].fz : cy[CORDIC_STEPS].z;
  assign diff = (ZW+1)'(zb) - (ZW+1)'(zy);
  assign dbs  = $signed({{(ZW-15){1'b0}}, db_q});

  always_comb begin
    if (diff > dbs)       turn_d = TURN_POS;
    else if (diff < -dbs) turn_d = TURN_NEG;
    else                  turn_d = TURN_STOP;
  end

  // turn command waits for the force path
  always_ff @(posedge clk_i) begin
    if (adv) begin
      turn_q <= turn_d;
      tl_q[0] <= turn_q;
      for (int i = 1; i < TD; i++) tl_q[i] <= tl_q[i-1];
    end
  end

  // offset data beside the root and divide rows
  side_t sd_q [SIDE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= side4_q;
      for (int i = 1; i < SIDE_DEPTH; i++) sd_q[i] <= sd_q[i-1];
    end
  end

  // square root row
  sqrt_t sq [SQ_STEPS+1];

  assign sq[0].rem   = '0;
  assign sq[0].root  = '0;
  assign sq[0].srest = SQW'(s4_q);

  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    psc_sqrt_cell u_sqrt (
      .clk_i (clk_i), .en_i (adv), .s_i (sq[j]), .s_o (sq[j+1])
    );
  end

  // strength times offset magnitude
  div_t div0_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div0_q.rem_x <= str_q * sd_q[SQ_STEPS-1].adx;
      div0_q.rem_y <= str_q * sd_q[SQ_STEPS-1].ady;
      div0_q.q_x   <= '0;
      div0_q.q_y   <= '0;
      div0_q.d     <= sq[SQ_STEPS].root;
    end
  end

  // divide row, saturation bit first
  div_t dv [DIV_STEPS+1];

  assign dv[0] = div0_q;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    psc_div_cell #(.BIT(DIV_STEPS-1-k)) u_div (
      .clk_i (clk_i), .en_i (adv), .v_i (dv[k]), .v_o (dv[k+1])
    );
  end

  // signed, saturated force component
  function automatic logic [31:0] force_cmd(input logic [DIV_STEPS-1:0] q,
                                            input logic neg, input logic dz);
    logic big;
    big = q[32] | q[31];
    if (dz)       return '0;
    else if (neg) return big ? 32'h8000_0000 : 32'(-q[31:0]);
    else          return big ? 32'h7fff_ffff : q[31:0];
  endfunction

  // saturated velocity component
  function automatic logic [31:0] vel_cmd(input logic signed [32:0] d);
    if (d[32] != d[31]) return d[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    else                return d[31:0];
  endfunction

  // output register
  side_t       sdo;
  div_t        dvo;
  logic        dz;
  turn_e       out_turn_q;
  drive_e      out_mode_q;
  logic [31:0] out_cx_q, out_cy_q;

  assign sdo = sd_q[SIDE_DEPTH-1];
  assign dvo = dv[DIV_STEPS];
  assign dz  = dvo.d == '0;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_turn_q <= tl_q[TD-1];
      if (sdo.force_m) begin
        out_mode_q <= DRIVE_FORCE;
        out_cx_q   <= force_cmd(dvo.q_x, sdo.dx[32], dz);
        out_cy_q   <= force_cmd(dvo.q_y, sdo.dy[32], dz);
      end else begin
        out_mode_q <= DRIVE_VEL;
        out_cx_q   <= vel_cmd(sdo.dx);
        out_cy_q   <= vel_cmd(sdo.dy);
      end
    end
  end

  assign m_axis_tdata_o = {6'b0, out_cy_q, out_cx_q, out_turn_q};
  assign m_axis_tuser_o = out_mode_q;

endmodule

FILE: hw/rtl/psc_checker.sv
// port-level checks for the pursuit steering command block, bound to the top level
module psc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [71:0]  m_axis_tdata_o,
  input logic [0:0]   m_axis_tuser_o,
  input logic         cfg_ready_o
);

  // input side opens exactly when the output slot frees
  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not track output slot");

  // the turn command never carries the unused code
  a_turn_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3)
    else $error("turn command out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // the configuration channel never pushes back
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("configuration channel not ready");

endmodule

bind pursuit_steering_command_top psc_checker u_psc_checker (.*);
